// ===== rtl/m3i_pkg.sv =====
// ----------------------------------------------------------------------------
// m3i_pkg
// Widths, types and cofactor index table for the 3x3 inverse pipeline.
// ----------------------------------------------------------------------------
package m3i_pkg;

  localparam int EW    = 32;
  localparam int FB    = 16;
  localparam int NE    = 9;
  localparam int PW    = 2 * EW;
  localparam int CW    = PW + 1;
  localparam int HW    = CW - EW;
  localparam int PPW   = EW + HW;
  localparam int DW    = EW + CW + 2;
  localparam int NW    = DW + 1;
  localparam int RW    = NW + EW;
  localparam int SH    = 2 * FB + 1;
  localparam int FRONT = 6;
  localparam int NS    = FRONT + EW + 1;

  typedef logic signed [EW-1:0]  elem_t;
  typedef logic signed [PW-1:0]  prod_t;
  typedef logic signed [CW-1:0]  cof_t;
  typedef logic signed [PPW-1:0] part_t;
  typedef logic signed [DW-1:0]  det_t;

  typedef struct packed {
    logic [NW-1:0] rem;
    logic [EW-1:0] q;
    logic          neg;
    logic          ovf;
  } lane_t;

  typedef struct packed {
    lane_t [NE-1:0] lane;
    logic [RW-2:0]  dsh;
    logic           sing;
  } div_t;

  localparam int unsigned COF_IDX [NE][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

endpackage

// ===== rtl/m3i_div_step.sv =====
// ----------------------------------------------------------------------------
// m3i_div_step
// One restoring division step for all nine lanes against a shared divisor.
// ----------------------------------------------------------------------------
module m3i_div_step import m3i_pkg::*; (
  input  logic clk,
  input  logic en,
  input  div_t d_in,
  output div_t d_out
);

  div_t step_r;
  div_t step_nxt;

  always_comb begin
    logic ge;
    step_nxt      = d_in;
    step_nxt.dsh  = d_in.dsh >> 1;
    for (int l = 0; l < NE; l++) begin
      ge = {{(RW-1-NW){1'b0}}, d_in.lane[l].rem} >= d_in.dsh;
      step_nxt.lane[l].q = {d_in.lane[l].q[EW-2:0], ge};
      if (ge) begin
        step_nxt.lane[l].rem = d_in.lane[l].rem - d_in.dsh[NW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      step_r <= step_nxt;
    end
  end

  assign d_out = step_r;

endmodule

// ===== rtl/matrix3x3_inverse.sv =====
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Stages from accepted input word to output word: 6 front stages,
// 32 quotient stages, one output register. Throughput: one word per cycle;
// each stage holds when the next is full and stalled, bubbles collapse.
// Reset clears only the stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module matrix3x3_inverse import m3i_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_a00,
  input  logic [31:0] in_a01,
  input  logic [31:0] in_a02,
  input  logic [31:0] in_a10,
  input  logic [31:0] in_a11,
  input  logic [31:0] in_a12,
  input  logic [31:0] in_a20,
  input  logic [31:0] in_a21,
  input  logic [31:0] in_a22,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_b00,
  output logic [31:0] out_b01,
  output logic [31:0] out_b02,
  output logic [31:0] out_b10,
  output logic [31:0] out_b11,
  output logic [31:0] out_b12,
  output logic [31:0] out_b20,
  output logic [31:0] out_b21,
  output logic [31:0] out_b22,
  output logic        out_singular,
  output logic        out_saturated
);

  elem_t         a [NE];
  logic [NS-1:0] vld_r;
  logic [NS-1:0] vld_in;
  logic [NS-1:0] en;

  assign a[0] = $signed(in_a00);
  assign a[1] = $signed(in_a01);
  assign a[2] = $signed(in_a02);
  assign a[3] = $signed(in_a10);
  assign a[4] = $signed(in_a11);
  assign a[5] = $signed(in_a12);
  assign a[6] = $signed(in_a20);
  assign a[7] = $signed(in_a21);
  assign a[8] = $signed(in_a22);

  always_comb begin
    en[NS-1] = !vld_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign vld_in   = {vld_r[NS-2:0], in_valid};
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_in[k];
        end
      end
    end
  end

  // products
  prod_t s1_p_r [NE][2];
  elem_t s1_a_r [3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int l = 0; l < NE; l++) begin
        s1_p_r[l][0] <= a[COF_IDX[l][0]] * a[COF_IDX[l][1]];
        s1_p_r[l][1] <= a[COF_IDX[l][2]] * a[COF_IDX[l][3]];
      end
      for (int t = 0; t < 3; t++) begin
        s1_a_r[t] <= a[t];
      end
    end
  end

  // cofactors
  cof_t  s2_c_r [NE];
  elem_t s2_a_r [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int l = 0; l < NE; l++) begin
        s2_c_r[l] <= CW'(s1_p_r[l][0]) - CW'(s1_p_r[l][1]);
      end
      s2_a_r <= s1_a_r;
    end
  end

  // determinant partial products
  cof_t  s3_c_r  [NE];
  part_t s3_lo_r [3];
  part_t s3_hi_r [3];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_c_r <= s2_c_r;
      for (int t = 0; t < 3; t++) begin
        s3_lo_r[t] <= s2_a_r[t] * $signed({1'b0, s2_c_r[3*t][EW-1:0]});
        s3_hi_r[t] <= s2_a_r[t] * $signed(s2_c_r[3*t][CW-1:EW]);
      end
    end
  end

  // determinant
  cof_t s4_c_r [NE];
  det_t s4_det_r;
  det_t det_nxt;

  always_comb begin
    det_nxt = '0;
    for (int t = 0; t < 3; t++) begin
      det_nxt = det_nxt + (DW'(s3_hi_r[t]) <<< EW) + DW'(s3_lo_r[t]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_c_r   <= s3_c_r;
      s4_det_r <= det_nxt;
    end
  end

  // magnitudes and signs
  logic [CW-1:0] s5_cabs_r [NE];
  logic [NE-1:0] s5_neg_r;
  logic [DW-1:0] s5_dabs_r;
  logic          s5_sing_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int l = 0; l < NE; l++) begin
        s5_cabs_r[l] <= s4_c_r[l][CW-1] ? CW'(-s4_c_r[l]) : CW'(s4_c_r[l]);
        s5_neg_r[l]  <= s4_c_r[l][CW-1] ^ s4_det_r[DW-1];
      end
      s5_dabs_r <= s4_det_r[DW-1] ? DW'(-s4_det_r) : DW'(s4_det_r);
      s5_sing_r <= s4_det_r == '0;
    end
  end

  // rounded numerator, doubled divisor, overflow check
  div_t          s6_r;
  div_t          s6_nxt;
  logic [NW-1:0] d2;

  always_comb begin
    logic [NW-1:0] n;
    d2          = {s5_dabs_r, 1'b0};
    s6_nxt.sing = s5_sing_r;
    s6_nxt.dsh  = (RW-1)'(d2) << (EW - 1);
    for (int l = 0; l < NE; l++) begin
      n = (NW'(s5_cabs_r[l]) << SH) + NW'(s5_dabs_r);
      s6_nxt.lane[l].rem = n;
      s6_nxt.lane[l].q   = '0;
      s6_nxt.lane[l].neg = s5_neg_r[l];
      s6_nxt.lane[l].ovf = RW'(n) >= (RW'(d2) << EW);
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_r <= s6_nxt;
    end
  end

  // quotient stages
  div_t dv [EW+1];
  assign dv[0] = s6_r;

  for (genvar g = 0; g < EW; g++) begin : g_div
    m3i_div_step u_step (
      .clk   (clk),
      .en    (en[FRONT+g]),
      .d_in  (dv[g]),
      .d_out (dv[g+1])
    );
  end

  // round-off, saturate, sign
  elem_t         b_r [NE];
  elem_t         b_nxt [NE];
  logic          sing_r;
  logic          sat_r;
  logic [NE-1:0] sat_l;

  always_comb begin
    lane_t         ln;
    logic [EW-1:0] lim;
    for (int l = 0; l < NE; l++) begin
      ln  = dv[EW].lane[l];
      lim = {1'b0, {(EW-1){1'b1}}} + EW'(ln.neg);
      sat_l[l] = !dv[EW].sing && (ln.ovf || ln.q > lim);
      if (dv[EW].sing || ln.q == '0) begin
        b_nxt[l] = '0;
      end else if (sat_l[l]) begin
        b_nxt[l] = ln.neg ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
      end else begin
        b_nxt[l] = ln.neg ? $signed(-ln.q) : $signed(ln.q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      b_r    <= b_nxt;
      sing_r <= dv[EW].sing;
      sat_r  <= |sat_l;
    end
  end

  assign out_valid     = vld_r[NS-1];
  assign out_b00       = b_r[0];
  assign out_b01       = b_r[1];
  assign out_b02       = b_r[2];
  assign out_b10       = b_r[3];
  assign out_b11       = b_r[4];
  assign out_b12       = b_r[5];
  assign out_b20       = b_r[6];
  assign out_b21       = b_r[7];
  assign out_b22       = b_r[8];
  assign out_singular  = sing_r;
  assign out_saturated = sat_r;

`ifndef SYNTHESIS
  a_sing_no_sat : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> !out_saturated)
    else $error("singular word flagged saturated");

  a_sing_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> (out_b00 == '0) && (out_b11 == '0) &&
    (out_b22 == '0) && (out_b01 == '0) && (out_b12 == '0) && (out_b20 == '0))
    else $error("singular word with nonzero entries");

  a_full_stall : assert property (@(posedge clk) disable iff (!rst_n)
    (&vld_r) && !out_ready |-> !in_ready)
    else $error("input taken while pipeline full and stalled");
`endif

endmodule

// ===== dv/tb_matrix3x3_inverse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix3x3_inverse
// Drives 3x3 signed Q16.16 matrices through the inverse pipeline under
// varying sender gaps and receiver stalls, and checks every output word
// against an exact adjugate-over-determinant prediction with rounding to
// nearest (ties away from zero), saturation and singular handling.
// ----------------------------------------------------------------------------
module tb_matrix3x3_inverse;

  typedef logic signed [31:0] q16_t;

  typedef struct {
    q16_t b[9];
    logic singular;
    logic saturated;
  } inverse_t;

  function automatic inverse_t invert_matrix(input q16_t a[9]);
    inverse_t r;
    logic signed [255:0] c[9];
    logic signed [255:0] det, n, d, q;
    logic neg;
    logic [255:0] lim;
    c[0] = 256'(a[4]) * a[8] - 256'(a[5]) * a[7];
    c[1] = 256'(a[2]) * a[7] - 256'(a[1]) * a[8];
    c[2] = 256'(a[1]) * a[5] - 256'(a[2]) * a[4];
    c[3] = 256'(a[5]) * a[6] - 256'(a[3]) * a[8];
    c[4] = 256'(a[0]) * a[8] - 256'(a[2]) * a[6];
    c[5] = 256'(a[2]) * a[3] - 256'(a[0]) * a[5];
    c[6] = 256'(a[3]) * a[7] - 256'(a[4]) * a[6];
    c[7] = 256'(a[1]) * a[6] - 256'(a[0]) * a[7];
    c[8] = 256'(a[0]) * a[4] - 256'(a[1]) * a[3];
    det = 256'(a[0]) * c[0] + 256'(a[1]) * c[3] + 256'(a[2]) * c[6];
    r.singular = (det == 0);
    r.saturated = 1'b0;
    for (int i = 0; i < 9; i++) r.b[i] = '0;
    if (r.singular) return r;
    d = det < 0 ? -det : det;
    for (int i = 0; i < 9; i++) begin
      neg = (c[i] < 0) != (det < 0);
      n = c[i] < 0 ? -c[i] : c[i];
      n = (n <<< 33) + d;
      q = $unsigned(n) / $unsigned(d <<< 1);
      lim = neg ? 256'h8000_0000 : 256'h7fff_ffff;
      if (q == 0) r.b[i] = '0;
      else if ($unsigned(q) > lim) begin
        r.saturated = 1'b1;
        r.b[i] = neg ? 32'h8000_0000 : 32'h7fff_ffff;
      end else r.b[i] = neg ? -q[31:0] : q[31:0];
    end
    return r;
  endfunction

  class inverse_scoreboard;
    inverse_t pending[$];
    int errors;

    function void note_matrix(input q16_t a[9]);
      pending.push_back(invert_matrix(a));
    endfunction

    function void check_inverse(input inverse_t got);
      inverse_t want;
      if (pending.size() == 0) begin
        $error("output word with no matrix pending");
        errors++;
        return;
      end
      want = pending.pop_front();
      for (int i = 0; i < 9; i++)
        if (got.b[i] !== want.b[i]) begin
          $error("b%0d%0d expected %h actual %h", i / 3, i % 3, want.b[i], got.b[i]);
          errors++;
        end
      if (got.singular !== want.singular) begin
        $error("singular expected %b actual %b", want.singular, got.singular);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated expected %b actual %b", want.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, in_valid, in_ready, out_valid, out_ready;
  logic [31:0] in_a[9];
  logic [31:0] out_b[9];
  logic out_singular, out_saturated;
  int send_idle_pct, recv_stall_pct, quiet_cycles;
  bit done;
  inverse_scoreboard sb;

  matrix3x3_inverse dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_a00(in_a[0]), .in_a01(in_a[1]), .in_a02(in_a[2]),
    .in_a10(in_a[3]), .in_a11(in_a[4]), .in_a12(in_a[5]),
    .in_a20(in_a[6]), .in_a21(in_a[7]), .in_a22(in_a[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_b00(out_b[0]), .out_b01(out_b[1]), .out_b02(out_b[2]),
    .out_b10(out_b[3]), .out_b11(out_b[4]), .out_b12(out_b[5]),
    .out_b20(out_b[6]), .out_b21(out_b[7]), .out_b22(out_b[8]),
    .out_singular(out_singular), .out_saturated(out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_matrix(input q16_t a[9]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int i = 0; i < 9; i++) in_a[i] <= a[i];
    do @(posedge clk); while (!in_ready);
    sb.note_matrix(a);
  endtask

  function automatic q16_t rand_entry(input int kind);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(131072)) - 65536;
      2: return $signed($urandom_range(2048)) - 1024;
      3: return $signed($urandom_range(16777216)) - 8388608;
      default: begin
        case ($urandom_range(4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 0;
          3: return 32'h0001_0000;
          default: return 32'hffff_ffff;
        endcase
      end
    endcase
  endfunction

  function automatic void random_matrix(output q16_t a[9]);
    int kind;
    kind = $urandom_range(5);
    for (int i = 0; i < 9; i++)
      a[i] = rand_entry(kind == 5 ? $urandom_range(4) : kind);
    if ($urandom_range(9) == 0) begin
      for (int i = 0; i < 3; i++) a[6 + i] = a[3 + i];
    end else if ($urandom_range(9) == 0) begin
      for (int i = 0; i < 9; i++) a[i] = (i % 4 == 0) ? rand_entry(kind) : 0;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_valid && out_ready) begin
      inverse_t got;
      for (int i = 0; i < 9; i++) got.b[i] = out_b[i];
      got.singular = out_singular;
      got.saturated = out_saturated;
      sb.check_inverse(got);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000 && !done) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    q16_t m[9];
    int pct[4][2];
    pct = '{'{0, 0}, '{84, 0}, '{0, 84}, '{34, 34}};
    sb = new();
    done = 1'b0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    for (int i = 0; i < 9; i++) in_a[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? 32'h0001_0000 : 0;
    send_matrix(m);
    for (int k = 0; k < 9; k++) m[k] = 0;
    send_matrix(m);
    for (int k = 0; k < 9; k++) m[k] = 32'h8000_0000;
    send_matrix(m);
    for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? 32'h0000_0001 : 0;
    send_matrix(m);
    for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? 32'h7fff_ffff : 0;
    send_matrix(m);
    for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? 32'h8000_0000 : 0;
    send_matrix(m);
    for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? 32'hffff_ffff : 0;
    send_matrix(m);
    for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? 32'h0002_0000 : 0;
    send_matrix(m);
    for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? 32'h0003_0000 : 0;
    send_matrix(m);
    m = '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0000_0000, 32'h0001_0000,
          32'h0004_0000, 32'h0005_0000, 32'h0006_0000, 32'h0000_0000};
    send_matrix(m);
    m = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0,
          32'h0, 32'h0, 32'h7fff_ffff};
    send_matrix(m);
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = pct[p][0];
      recv_stall_pct = pct[p][1];
      repeat (250) begin
        random_matrix(m);
        send_matrix(m);
      end
    end
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    done = 1'b1;
    repeat (100) @(posedge clk);
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
